[src/tseq_pkg.sv]
// Shared types and constants of the sorted timer event queue.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package tseq_pkg;

  // Queue depth must be a power of two: slots form a ring addressed modulo depth.
  localparam int QUEUE_DEPTH = 64;
  localparam int AW          = $clog2(QUEUE_DEPTH);
  localparam int CW          = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_OUT     = 64;
  localparam int KW          = $clog2(MAX_OUT + 1);

  localparam int IN_DATA_W  = 208;
  localparam int OUT_DATA_W = 208;

  // Largest ms difference whose microsecond value still fits in 64 bits.
  localparam logic [63:0] DELAY_SAT_LIM = 64'hFFFF_FFFF_FFFF_FFFF / 64'd1000;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_EXPIRE = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_MATCH = 2'd2,
    ST_NOT_DUE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    DLY_ZERO,
    DLY_ONE,
    DLY_CALC
  } delay_mode_t;

  typedef struct packed {
    logic [63:0] deadline;
    logic [31:0] key;
    logic [7:0]  tag;
    logic [31:0] handle;
  } entry_t;

  localparam int EW = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT,
    S_INS_WR,
    S_EXP_RD,
    S_EXP_CHK,
    S_HEAD_RD,
    S_HEAD_WAIT,
    S_DLY1,
    S_DLY2,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic shift;
    logic ins_wr;
    logic exp_rd;
    logic exp_chk;
    logic head_rd;
    logic head_wait;
    logic dly1;
    logic dly2;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  scan_done;
    logic  shift_done;
    logic  res_last;
  } dp_status_t;

endpackage

`default_nettype wire

[src/tseq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tseq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[src/tseq_ctrl.sv]
// Controller state machine of the timer queue.
// Depends on tseq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tseq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  input  wire tseq_pkg::dp_status_t sts,
  output tseq_pkg::ctrl_cmd_t      cmd
);
  import tseq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (sts.kind == KIND_EXPIRE) begin
          state_nxt = S_EXP_RD;
        end else if (sts.kind == KIND_INSERT && sts.full) begin
          state_nxt = S_HEAD_RD;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = (sts.kind == KIND_INSERT) ? S_SHIFT : S_HEAD_RD;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) begin
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = S_HEAD_RD;
      end
      S_EXP_RD: begin
        cmd.exp_rd = 1'b1;
        state_nxt  = S_EXP_CHK;
      end
      S_EXP_CHK: begin
        cmd.exp_chk = 1'b1;
        state_nxt   = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        cmd.head_rd = 1'b1;
        state_nxt   = S_HEAD_WAIT;
      end
      S_HEAD_WAIT: begin
        cmd.head_wait = 1'b1;
        state_nxt     = S_DLY1;
      end
      S_DLY1: begin
        cmd.dly1  = 1'b1;
        state_nxt = S_DLY2;
      end
      S_DLY2: begin
        cmd.dly2  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = sts.res_last ? S_IDLE : S_EXP_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[src/tseq_dp.sv]
// Datapath of the timer queue: slot ring RAM, scan/shift counters,
// due check, head delay arithmetic and the result register.
// Depends on tseq_pkg and tseq_ram.
`timescale 1ns / 1ps
`default_nettype none

module tseq_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tseq_pkg::ctrl_cmd_t             cmd,
  output tseq_pkg::dp_status_t                 sts,
  input  wire logic [tseq_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [1:0]                      in_tuser,
  input  wire logic                            cfg_valid,
  input  wire logic [15:0]                     cfg_data,
  output logic      [tseq_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic      [1:0]                      out_tuser,
  output logic                                 out_tlast
);
  import tseq_pkg::*;

  // queue state
  logic [15:0]   tol_r;
  logic [CW-1:0] occ_r;
  logic [AW-1:0] head_r;

  // current item
  kind_t         kind_r;
  logic [63:0]   now_r;
  entry_t        ent_in_r;
  logic          any_r;
  logic [64:0]   lim_r;

  // scan and shift bookkeeping
  logic [CW-1:0] i_r, pi_r, w_r, pos_r, n_r, j_r;
  logic          pend_r, pend_nxt;
  logic [6:0]    rem_r;
  logic [KW-1:0] k_r;

  // result under construction
  status_t       res_status_r;
  entry_t        res_ent_r;
  logic          res_due_r;
  logic          res_last_r;
  delay_mode_t   dmode_r;
  logic [63:0]   diff_r, a_r;
  logic          sat_r;

  // result register
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [1:0]            out_tuser_r;
  logic                  out_tlast_r;

  // RAM port
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        wr_ent, rd_ent;
  logic [EW-1:0] rd_data;

  logic          rd_match, ins_stop, stop_cond, stop_now, issue, scan_done, scan_eval;
  logic          sh_issue, shift_done, head_due, exp_due;
  logic [CW-1:0] pos_sel;
  logic [63:0]   delay;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] idx);
    phys = head + idx[AW-1:0];
  endfunction

  function automatic logic is_due(input logic [64:0] lim, input logic [63:0] dl);
    is_due = lim[64] | (dl < lim[63:0]);
  endfunction

  tseq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_ent),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_ent = entry_t'(rd_data);

  always_comb begin
    rd_match  = (rd_ent.key == ent_in_r.key) && (any_r || rd_ent.tag == ent_in_r.tag);
    ins_stop  = (pi_r == '0) ? (rd_ent.deadline > ent_in_r.deadline)
                             : !(rd_ent.deadline < ent_in_r.deadline);
    unique case (kind_r)
      KIND_INSERT: stop_cond = ins_stop;
      KIND_LOOKUP: stop_cond = rd_match;
      default:     stop_cond = 1'b0;
    endcase
    scan_eval  = cmd.scan && pend_r;
    stop_now   = scan_eval && stop_cond;
    issue      = cmd.scan && !stop_now && (i_r < occ_r);
    scan_done  = cmd.scan && (stop_now || (!pend_r && i_r >= occ_r));
    pos_sel    = stop_now ? pi_r : occ_r;
    sh_issue   = cmd.shift && (n_r != '0);
    shift_done = cmd.shift && (n_r == '0) && !pend_r;
    pend_nxt   = issue || sh_issue;
    exp_due    = (occ_r != '0) && is_due(lim_r, rd_ent.deadline);
    head_due   = is_due(lim_r, rd_ent.deadline);
  end

  // RAM read and write selection
  always_comb begin
    rd_en   = issue || sh_issue || cmd.exp_rd || cmd.head_rd;
    rd_addr = head_r;
    if (issue) begin
      rd_addr = phys(head_r, i_r);
    end else if (sh_issue) begin
      rd_addr = phys(head_r, j_r);
    end
    wr_en   = 1'b0;
    wr_addr = phys(head_r, w_r);
    wr_ent  = rd_ent;
    priority if (scan_eval && kind_r == KIND_REMOVE && !rd_match) begin
      wr_en = 1'b1;
    end else if (cmd.shift && pend_r) begin
      wr_en   = 1'b1;
      wr_addr = phys(head_r, pi_r + CW'(1));
    end else if (cmd.ins_wr) begin
      wr_en   = 1'b1;
      wr_addr = phys(head_r, pos_r);
      wr_ent  = ent_in_r;
    end else begin
      wr_en = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= '0;
      occ_r  <= '0;
      head_r <= '0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (cfg_valid) begin
        tol_r <= cfg_data;
      end
      if (scan_done && kind_r == KIND_REMOVE) begin
        occ_r <= w_r;
      end
      if (cmd.ins_wr) begin
        occ_r <= occ_r + CW'(1);
      end
      if (cmd.exp_chk && exp_due) begin
        occ_r  <= occ_r - CW'(1);
        head_r <= head_r + AW'(1);
      end
    end
  end

  // payload and counters, initialized on every accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r            <= kind_t'(in_tuser);
      now_r             <= in_tdata[63:0];
      ent_in_r.deadline <= in_tdata[127:64];
      ent_in_r.key      <= in_tdata[159:128];
      ent_in_r.tag      <= in_tdata[167:160];
      any_r             <= in_tdata[168];
      ent_in_r.handle   <= in_tdata[200:169];
      lim_r             <= {1'b0, in_tdata[63:0]} + {49'd0, tol_r};
      i_r               <= '0;
      w_r               <= '0;
      rem_r             <= '0;
      k_r               <= '0;
      res_ent_r         <= '0;
      res_due_r         <= 1'b0;
      res_status_r      <= (kind_t'(in_tuser) == KIND_INSERT &&
                            occ_r == CW'(QUEUE_DEPTH)) ? ST_FULL : ST_OK;
    end
    if (scan_eval && kind_r == KIND_REMOVE) begin
      if (rd_match) begin
        if (rem_r != 7'h7F) begin
          rem_r <= rem_r + 7'd1;
        end
      end else begin
        w_r <= w_r + CW'(1);
      end
    end
    if (issue) begin
      i_r  <= i_r + CW'(1);
      pi_r <= i_r;
    end
    if (scan_done) begin
      unique case (kind_r)
        KIND_INSERT: begin
          pos_r <= pos_sel;
          n_r   <= occ_r - pos_sel;
          j_r   <= occ_r - CW'(1);
        end
        KIND_LOOKUP: begin
          if (stop_now) begin
            res_ent_r    <= rd_ent;
            res_due_r    <= is_due(lim_r, rd_ent.deadline);
            res_status_r <= ST_OK;
          end else begin
            res_status_r <= ST_NO_MATCH;
          end
        end
        KIND_REMOVE: res_status_r <= (rem_r != '0) ? ST_OK : ST_NO_MATCH;
        default: ;
      endcase
    end
    if (sh_issue) begin
      j_r  <= j_r - CW'(1);
      n_r  <= n_r - CW'(1);
      pi_r <= j_r;
    end
    if (cmd.exp_chk) begin
      if (exp_due) begin
        res_ent_r    <= rd_ent;
        res_status_r <= ST_OK;
        k_r          <= k_r + KW'(1);
      end else begin
        res_ent_r    <= '0;
        res_status_r <= ST_NOT_DUE;
      end
    end
    if (cmd.head_wait) begin
      priority if (occ_r == '0) begin
        dmode_r <= DLY_ZERO;
      end else if (rd_ent.deadline <= now_r) begin
        dmode_r <= DLY_ONE;
      end else begin
        dmode_r <= DLY_CALC;
      end
      diff_r <= rd_ent.deadline - now_r;
      if (kind_r == KIND_EXPIRE && res_status_r == ST_OK) begin
        res_last_r <= (k_r == KW'(MAX_OUT)) || (occ_r == '0) || !head_due;
      end else begin
        res_last_r <= 1'b1;
      end
    end
    if (cmd.dly1) begin
      // x * 1000 = x * 1024 - x * 16 - x * 8
      a_r   <= (diff_r << 10) - (diff_r << 4);
      sat_r <= diff_r > DELAY_SAT_LIM;
    end
    if (cmd.dly2) begin
      out_tdata_r <= {delay, rem_r, res_due_r, res_ent_r.handle, res_ent_r.tag,
                      res_ent_r.key, res_ent_r.deadline};
      out_tuser_r <= res_status_r;
      out_tlast_r <= res_last_r;
    end
  end

  always_comb begin
    unique case (dmode_r)
      DLY_ZERO: delay = '0;
      DLY_ONE:  delay = 64'd1;
      default:  delay = sat_r ? '1 : (a_r - (diff_r << 3));
    endcase
  end

  assign sts.kind       = kind_r;
  assign sts.full       = (occ_r == CW'(QUEUE_DEPTH));
  assign sts.scan_done  = scan_done;
  assign sts.shift_done = shift_done;
  assign sts.res_last   = res_last_r;

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;
  assign out_tlast = out_tlast_r;

endmodule

`default_nettype wire

[src/sorted_timer_event_queue.sv]
// Top level of the sorted timer event queue: controller plus datapath.
// Depends on tseq_pkg, tseq_ctrl, tseq_dp (and tseq_ram through tseq_dp).
`timescale 1ns / 1ps
`default_nettype none

// Sorted timer queue of up to QUEUE_DEPTH entries (deadline, key, tag, handle),
// head first, held in a single-port-read ring RAM with a head pointer, so expiring
// the head is a pointer bump rather than a shift. One transaction in at a time:
// in_tready is high only while the block is idle, and every result is held in
// the output register until taken. Steps per transaction, all bounded by the
// one RAM read per cycle:
//   insert : scan for the slot, then shift the tail up; neither when full
//   remove : one compacting pass
//   lookup : scan stops at the first match
//   expire : pops due entries from the head, one result per popped entry,
//            or a single result when nothing is due
// No clearing pass after reset: only slots below the occupancy count are ever
// read. The delay field is computed from the head after the operation, with a
// shift-and-subtract times 1000.
// due_tolerance_ms is written through cfg_valid/cfg_data, which are always ready;
// write it only while the block is idle.
module sorted_timer_event_queue (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input transaction
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [63:0] now_ms, [127:64] deadline_ms, [159:128] entry_key,
  // [167:160] entry_tag, [168] any_tag, [200:169] payload_handle, [207:201] zero
  input  wire logic [tseq_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic [1:0]                       in_tuser,   // [1:0] kind
  // result transaction
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [63:0] out_deadline, [95:64] out_key, [103:96] out_tag, [135:104] out_handle,
  // [136] is_due, [143:137] removed_count, [207:144] next_delay_us
  output logic      [tseq_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic      [1:0]                       out_tuser,  // [1:0] status
  output logic                                  out_tlast,  // last result of the item
  // configuration: due_tolerance_ms
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [15:0]                      cfg_data
);
  import tseq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  tseq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tseq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

endmodule

`default_nettype wire

[src/tseq_checker.sv]
// Port-level checks of the timer queue, bound to the top level.
// Depends on tseq_pkg and sorted_timer_event_queue.
`timescale 1ns / 1ps
`default_nettype none

module tseq_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [tseq_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [1:0]                      out_tuser,
  input wire logic                            out_tlast
);
  import tseq_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // one transaction in flight: nothing accepted while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while result pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second input accepted back to back");

  // only a successful expire pop may be followed by more results
  a_more_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == ST_OK)
    else $error("non-final result with error status");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL || out_tuser == ST_NOT_DUE) |-> out_tdata[135:0] == '0)
    else $error("error result carries an entry");

endmodule

bind sorted_timer_event_queue tseq_checker u_tseq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

`default_nettype wire

[verif/tb_sorted_timer_event_queue.sv]
// Self-checking testbench for sorted_timer_event_queue: directed and random timer operations
// checked against an in-bench queue predictor. Depends on tseq_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_sorted_timer_event_queue;
  import tseq_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] now;
    logic [63:0] deadline;
    logic [31:0] key;
    logic [7:0]  tag;
    logic        any_tag;
    logic [31:0] handle;
    logic        is_cfg;     // tolerance write instead of an operation
    logic        drain;      // wait until all results are back before sending
  } op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] deadline;
    logic [31:0] key;
    logic [7:0]  tag;
    logic [31:0] handle;
    logic        is_due;
    logic [6:0]  removed;
    logic [63:0] delay;
    logic        last;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_tready, out_tvalid, out_tlast, cfg_ready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  always #5 clk = ~clk;

  sorted_timer_event_queue DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state: timer list, head first
  logic [63:0] q_dl[$];
  logic [31:0] q_key[$];
  logic [7:0]  q_tag[$];
  logic [31:0] q_hdl[$];
  logic [15:0] tolerance = '0;

  op_t  pending_ops[$];
  res_t expected_results[$];
  int   errors = 0, n_results = 0, n_items = 0, n_cfg = 0;
  int   idle_cycles = 0;
  bit   stim_done = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic bit is_due_at(logic [63:0] dl, logic [63:0] now);
    logic [64:0] sum;
    sum = {1'b0, now} + tolerance;
    if (sum[64]) return 1'b1;
    return dl < sum[63:0];
  endfunction

  function automatic logic [63:0] head_delay_us(logic [63:0] now);
    logic [63:0] diff;
    if (q_dl.size() == 0) return 64'd0;
    if (q_dl[0] <= now) return 64'd1;
    diff = q_dl[0] - now;
    if (diff > DELAY_SAT_LIM) return '1;
    return diff * 64'd1000;
  endfunction

  function automatic res_t blank_res(logic [1:0] st, logic [63:0] now);
    res_t r;
    r = '0;
    r.status = st;
    r.delay = head_delay_us(now);
    r.last = 1'b1;
    return r;
  endfunction

  // Apply one operation to the timer list and queue up its results.
  task automatic predict_timer_op(op_t op);
    int pos, removed, popped;
    res_t r;
    bit hit;
    case (kind_t'(op.kind))
      KIND_INSERT: begin
        if (q_dl.size() >= QUEUE_DEPTH) begin
          expected_results.push_back(blank_res(ST_FULL, op.now));
        end else begin
          if (q_dl.size() == 0 || q_dl[0] > op.deadline) pos = 0;
          else begin
            pos = 1;
            while (pos < q_dl.size() && q_dl[pos] < op.deadline) pos++;
          end
          q_dl.insert(pos, op.deadline);
          q_key.insert(pos, op.key);
          q_tag.insert(pos, op.tag);
          q_hdl.insert(pos, op.handle);
          expected_results.push_back(blank_res(ST_OK, op.now));
        end
      end
      KIND_REMOVE: begin
        removed = 0;
        pos = 0;
        while (pos < q_dl.size()) begin
          if (q_key[pos] == op.key && (op.any_tag || q_tag[pos] == op.tag)) begin
            q_dl.delete(pos); q_key.delete(pos); q_tag.delete(pos); q_hdl.delete(pos);
            removed++;
          end else pos++;
        end
        r = blank_res(removed != 0 ? ST_OK : ST_NO_MATCH, op.now);
        r.removed = (removed > 127) ? 7'd127 : removed[6:0];
        expected_results.push_back(r);
      end
      KIND_EXPIRE: begin
        popped = 0;
        while (popped < MAX_OUT && q_dl.size() > 0 && is_due_at(q_dl[0], op.now)) begin
          r = '0;
          r.status = ST_OK;
          r.deadline = q_dl.pop_front();
          r.key = q_key.pop_front();
          r.tag = q_tag.pop_front();
          r.handle = q_hdl.pop_front();
          r.delay = head_delay_us(op.now);
          expected_results.push_back(r);
          popped++;
        end
        if (popped == 0) expected_results.push_back(blank_res(ST_NOT_DUE, op.now));
        else expected_results[$].last = 1'b1;
      end
      default: begin
        hit = 0;
        for (int i = 0; i < q_dl.size() && !hit; i++)
          if (q_key[i] == op.key && (op.any_tag || q_tag[i] == op.tag)) begin
            r = blank_res(ST_OK, op.now);
            r.deadline = q_dl[i]; r.key = q_key[i]; r.tag = q_tag[i]; r.handle = q_hdl[i];
            r.is_due = is_due_at(q_dl[i], op.now);
            expected_results.push_back(r);
            hit = 1;
          end
        if (!hit) expected_results.push_back(blank_res(ST_NO_MATCH, op.now));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one transaction at a time from pending_ops. Config writes and
  // drain markers wait for every outstanding result plus a settle pause.
  // ---------------------------------------------------------------------------
  int   send_gap = 0;
  int   settle = 0;
  op_t  cur_op;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_timer_op(cur_op);
        n_items++;
        in_tvalid <= 1'b0;
        send_gap = gap_len();
      end else if (cfg_valid && cfg_ready) begin
        tolerance = cfg_data;
        n_cfg++;
        cfg_valid <= 1'b0;
        send_gap = gap_len();
      end else if (!in_tvalid && !cfg_valid && pending_ops.size() > 0) begin
        if (send_gap > 0) send_gap--;
        else if ((pending_ops[0].is_cfg || pending_ops[0].drain) &&
                 expected_results.size() > 0) settle = 0;
        else if ((pending_ops[0].is_cfg || pending_ops[0].drain) && settle < 20) settle++;
        else begin
          cur_op = pending_ops.pop_front();
          settle = 0;
          if (cur_op.is_cfg) begin
            cfg_data <= cur_op.deadline[15:0];
            cfg_valid <= 1'b1;
          end else begin
            in_tdata <= {7'd0, cur_op.handle, cur_op.any_tag, cur_op.tag, cur_op.key,
                         cur_op.deadline, cur_op.now};
            in_tuser <= cur_op.kind;
            in_tvalid <= 1'b1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, each result checked against the oldest
  // expectation field by field.
  // ---------------------------------------------------------------------------
  int recv_gap = 0;
  res_t want, got;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.deadline = out_tdata[63:0];
        got.key = out_tdata[95:64];
        got.tag = out_tdata[103:96];
        got.handle = out_tdata[135:104];
        got.is_due = out_tdata[136];
        got.removed = out_tdata[143:137];
        got.delay = out_tdata[207:144];
        got.last = out_tlast;
        n_results++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          if (got.deadline !== want.deadline)
            $display("%0t: deadline exp %h got %h", $time, want.deadline, got.deadline);
          if (got.key !== want.key)
            $display("%0t: key exp %h got %h", $time, want.key, got.key);
          if (got.tag !== want.tag)
            $display("%0t: tag exp %h got %h", $time, want.tag, got.tag);
          if (got.handle !== want.handle)
            $display("%0t: handle exp %h got %h", $time, want.handle, got.handle);
          if (got.is_due !== want.is_due)
            $display("%0t: is_due exp %b got %b", $time, want.is_due, got.is_due);
          if (got.removed !== want.removed)
            $display("%0t: removed exp %0d got %0d", $time, want.removed, got.removed);
          if (got.delay !== want.delay)
            $display("%0t: delay exp %h got %h", $time, want.delay, got.delay);
          if (got.last !== want.last)
            $display("%0t: last exp %b got %b", $time, want.last, got.last);
          if (got !== want) errors++;
        end
        recv_gap = gap_len();
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else out_tready <= 1'b1;
    end
  end

  // Watchdog: cycles with no transaction on any channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("timeout: %0d results outstanding", expected_results.size());
      $display("tb_sorted_timer_event_queue NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_op(logic [1:0] k, logic [63:0] now, logic [63:0] dl, logic [31:0] key,
                        logic [7:0] tag, logic any, logic [31:0] hdl);
    op_t o;
    o = '0;
    o.kind = k; o.now = now; o.deadline = dl; o.key = key; o.tag = tag;
    o.any_tag = any; o.handle = hdl;
    pending_ops.push_back(o);
  endtask

  task automatic add_cfg(logic [15:0] v);
    op_t o;
    o = '0;
    o.is_cfg = 1'b1;
    o.deadline = v;
    pending_ops.push_back(o);
  endtask

  task automatic add_drain();
    op_t o;
    o = '0;
    o.drain = 1'b1;
    o.kind = KIND_LOOKUP;
    o.key = $urandom;
    pending_ops.push_back(o);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Small key/tag pools so removes and lookups hit; sometimes full-range values.
  function automatic logic [31:0] pick_key();
    return ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5);
  endfunction

  function automatic logic [7:0] pick_tag();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
  endfunction

  initial begin
    logic [63:0] base, now;
    int r;
    // directed: extremes and special cases
    add_cfg(16'd0);
    add_op(KIND_EXPIRE, 64'd100, 0, 0, 0, 0, 0);                 // nothing due, empty
    add_op(KIND_LOOKUP, 64'd100, 0, 1, 1, 1, 0);                 // miss, empty
    add_op(KIND_REMOVE, 64'd100, 0, 1, 1, 0, 0);                 // remove miss
    add_op(KIND_INSERT, 64'd0, '1, '1, 8'hFF, 1, '1);            // huge delay, saturates
    add_op(KIND_INSERT, 64'd0, 64'd500, 32'd7, 8'h00, 0, 32'd1);
    add_op(KIND_INSERT, 64'd0, 64'd500, 32'd7, 8'h01, 0, 32'd2); // equal deadlines
    add_op(KIND_INSERT, 64'd0, 64'd200, 32'd8, 8'h02, 0, 32'd3); // new head
    add_op(KIND_INSERT, 64'd0, 64'd200, 32'd9, 8'h02, 0, 32'd4); // equal to head
    add_op(KIND_LOOKUP, 64'd300, 0, 32'd7, 8'h01, 0, 0);         // exact tag, not due
    add_op(KIND_LOOKUP, 64'd1000, 0, 32'd7, 8'h55, 1, 0);        // wildcard
    add_op(KIND_REMOVE, 64'd100, 0, 32'd7, 8'h00, 1, 0);         // removes two
    add_op(KIND_EXPIRE, 64'd200, 0, 0, 0, 0, 0);                 // strictly below: none
    add_op(KIND_EXPIRE, 64'd201, 0, 0, 0, 0, 0);                 // pops both 200s
    add_cfg(16'hFFFF);
    add_op(KIND_EXPIRE, 64'hFFFF_FFFF_FFFF_FFF0, 0, 0, 0, 0, 0); // due sum overflows
    add_cfg(16'd5);
    // fill past capacity, then a single expire capped at 64 pops
    for (int i = 0; i < QUEUE_DEPTH + 2; i++)
      add_op(KIND_INSERT, 64'd10, 64'd20 + $urandom_range(0, 40), pick_key(), pick_tag(),
             0, $urandom);
    add_drain();
    add_op(KIND_EXPIRE, '1, 0, 0, 0, 0, 0);
    add_cfg(16'd0);

    // random: batches of mixed operations around a moving time base
    base = 64'd1000;
    for (int b = 0; b < 9; b++) begin
      if (b % 4 == 3) add_cfg($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 30)));
      if (b == 6) add_drain();
      for (int i = 0; i < 20; i++) begin
        now = base + $urandom_range(0, 50);
        r = $urandom_range(0, 99);
        if (r < 45)
          add_op(KIND_INSERT, ($urandom_range(0, 19) == 0) ? rand64() : now,
                 ($urandom_range(0, 19) == 0) ? rand64() : now + $urandom_range(0, 100),
                 pick_key(), pick_tag(), 1'($urandom_range(0, 1)), $urandom);
        else if (r < 60)
          add_op(KIND_REMOVE, now, rand64(), pick_key(), pick_tag(), 1'($urandom_range(0, 1)),
                 $urandom);
        else if (r < 80)
          add_op(KIND_EXPIRE, ($urandom_range(0, 19) == 0) ? rand64() : now, rand64(),
                 pick_key(), pick_tag(), 1'($urandom_range(0, 1)), $urandom);
        else
          add_op(KIND_LOOKUP, now, rand64(), pick_key(), pick_tag(), 1'($urandom_range(0, 1)),
                 $urandom);
      end
      base = base + $urandom_range(20, 80);
    end
    add_cfg(16'hFFFF);
    add_op(KIND_EXPIRE, '1, 0, 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_ops.size() == 0 && !in_tvalid && !cfg_valid);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);
    $display("covered %0d operations, %0d results, %0d tolerance writes",
             n_items, n_results, n_cfg);
    if (errors == 0 && expected_results.size() == 0)
      $display("tb_sorted_timer_event_queue OK");
    else
      $display("tb_sorted_timer_event_queue NOT OK");
    $finish;
  end

endmodule
